// File: rtl/als_pkg.sv
// Package: shared widths, register indexes and range thresholds for the light sampler.
`timescale 1ns / 1ps
`default_nettype none
package als_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int REG_W     = 16;
  localparam int MEAS_W    = 32;
  localparam int SUM_W     = 36;
  localparam int LEVEL_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int WINDOW_DEFAULT = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DARK_LOW_GAIN_OFF  = 3'd0,
    REG_DARK_LOW_GAIN_ON   = 3'd1,
    REG_DARK_HIGH_GAIN_OFF = 3'd2,
    REG_DARK_HIGH_GAIN_ON  = 3'd3,
    REG_SCALE_LEVEL0       = 3'd4,
    REG_SCALE_LEVEL1       = 3'd5,
    REG_SCALE_LEVEL2       = 3'd6
  } cfg_reg_t;

  // Range levels
  localparam logic [LEVEL_W-1:0] LVL_LOW_R_G0  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_LOW_R_G1  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_HIGH_R_G0 = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_HIGH_R_G1 = 2'd3;

  // Thresholds on the raw sample bits taken as unsigned
  localparam logic [SAMPLE_W-1:0] THR_UP        = 16'd1000;
  localparam logic [SAMPLE_W-1:0] THR_DOWN_HIGH = 16'd31000;
  localparam logic [SAMPLE_W-1:0] THR_DOWN_MID  = 16'd15000;

endpackage
`default_nettype wire

// File: rtl/als_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module als_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/autorange_light_sampler.sv
// Auto-ranging ADC sampler: range level control, dark/scale correction and moving window sum.
// An accepted sample beat passes the second-stage register, then the output register.
// Throughput: one sample per cycle unless the output stalls; the ring read at accept and the
// stage-two write-back overlap across items, with forwarding when both hit the same entry.
// A stalled result stalls the whole two-stage pipe and the input side.
// Reset (rst, synchronous): level 0, no drop armed, ring position 0, sum 0, every ring
// entry reads as zero until written, registers to their defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module autorange_light_sampler
  import als_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave side: tdata = sample[15:0]
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,
  // master side: tdata = window_sum[35:0], range_level[37:36], high_resistor[38],
  // high_gain[39]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [39:0]               m_tdata,
  // tuser = sample_dropped[0]
  output logic [0:0]                m_tuser,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [REG_W-1:0]     cfg_wdata
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  // configuration registers
  logic [REG_W-1:0] dark_low_gain_off, dark_low_gain_on;
  logic [REG_W-1:0] dark_high_gain_off, dark_high_gain_on;
  logic [REG_W-1:0] scale_level0, scale_level1, scale_level2;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_low_gain_off  <= '0;
      dark_low_gain_on   <= '0;
      dark_high_gain_off <= '0;
      dark_high_gain_on  <= '0;
      scale_level0       <= REG_W'(1);
      scale_level1       <= REG_W'(1);
      scale_level2       <= REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DARK_LOW_GAIN_OFF:  dark_low_gain_off  <= cfg_wdata;
        REG_DARK_LOW_GAIN_ON:   dark_low_gain_on   <= cfg_wdata;
        REG_DARK_HIGH_GAIN_OFF: dark_high_gain_off <= cfg_wdata;
        REG_DARK_HIGH_GAIN_ON:  dark_high_gain_on  <= cfg_wdata;
        REG_SCALE_LEVEL0:       scale_level0       <= cfg_wdata;
        REG_SCALE_LEVEL1:       scale_level1       <= cfg_wdata;
        REG_SCALE_LEVEL2:       scale_level2       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  logic [LEVEL_W-1:0] level, level_next;
  logic               drop_pending;
  logic [PTR_W-1:0]   ring_position, pos_next;
  logic [SUM_W-1:0]   running_sum, sum_next;
  logic [WINDOW-1:0]  entry_valid;

  // second stage
  logic               b_valid, b_drop, b_fwd, b_old_valid;
  logic [MEAS_W-1:0]  b_meas, b_fwd_data;
  logic [PTR_W-1:0]   b_addr;
  logic [LEVEL_W-1:0] b_level;

  logic adv, accept, b_write;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign b_write  = adv && b_valid && !b_drop;

  // first stage: dark/scale select, multiply, range step
  logic [REG_W-1:0]    dark, scale;
  logic [MEAS_W-1:0]   diff, prod;
  logic [SAMPLE_W-1:0] raw;
  logic                step_up, step_down;

  assign raw      = s_tdata;
  assign pos_next = (ring_position == PTR_LAST) ? '0 : ring_position + PTR_W'(1);

  always_comb begin
    case (level)
      LVL_LOW_R_G0:  begin dark = dark_low_gain_off;  scale = scale_level0; end
      LVL_LOW_R_G1:  begin dark = dark_low_gain_on;   scale = scale_level1; end
      LVL_HIGH_R_G0: begin dark = dark_high_gain_off; scale = scale_level2; end
      default:       begin dark = dark_high_gain_on;  scale = REG_W'(1);    end
    endcase
  end

  assign diff = {{(MEAS_W-SAMPLE_W){raw[SAMPLE_W-1]}}, raw} - {{(MEAS_W-REG_W){1'b0}}, dark};
  assign prod = MEAS_W'(diff * {{(MEAS_W-REG_W){1'b0}}, scale});

  always_comb begin
    step_up   = 1'b0;
    step_down = 1'b0;
    case (level)
      LVL_LOW_R_G0: step_up = raw < THR_UP;
      LVL_LOW_R_G1: begin
        step_down = raw > THR_DOWN_HIGH;
        step_up   = !step_down &&
                    ({1'b0, raw} < ({1'b0, THR_UP} + {1'b0, dark_low_gain_on}));
      end
      LVL_HIGH_R_G0: begin
        step_up   = raw < THR_UP;
        step_down = !step_up && (raw > THR_DOWN_MID);
      end
      default: step_down = raw > THR_DOWN_HIGH;
    endcase
  end

  always_comb begin
    level_next = level;
    if (step_up && level != LVL_HIGH_R_G1) begin
      level_next = level + LEVEL_W'(1);
    end else if (step_down && level != LVL_LOW_R_G0) begin
      level_next = level - LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= LVL_LOW_R_G0;
      drop_pending  <= 1'b0;
      ring_position <= '0;
    end else if (accept) begin
      if (drop_pending) begin
        drop_pending <= 1'b0;
      end else begin
        ring_position <= pos_next;
        level         <= level_next;
        drop_pending  <= level_next != level;
      end
    end
  end

  // ring memory: read at accept, write back one stage later
  logic [MEAS_W-1:0] ram_rdata;

  als_ram #(
    .WIDTH(MEAS_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (b_write),
    .waddr(b_addr),
    .wdata(b_meas),
    .re   (accept && !drop_pending),
    .raddr(pos_next),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_drop      <= drop_pending;
      b_meas      <= prod;
      b_addr      <= pos_next;
      b_level     <= drop_pending ? level : level_next;
      // the write-back leaving stage two this edge lands after the read: forward it
      b_fwd       <= b_valid && !b_drop && (b_addr == pos_next);
      b_fwd_data  <= b_meas;
      b_old_valid <= entry_valid[pos_next] || (b_valid && !b_drop && (b_addr == pos_next));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (b_write) begin
      entry_valid[b_addr] <= 1'b1;
    end
  end

  // second stage: retire old entry, add new one
  logic [MEAS_W-1:0] old_meas;
  assign old_meas = !b_old_valid ? '0 : (b_fwd ? b_fwd_data : ram_rdata);
  assign sum_next = running_sum
                  - {{(SUM_W-MEAS_W){old_meas[MEAS_W-1]}}, old_meas}
                  + {{(SUM_W-MEAS_W){b_meas[MEAS_W-1]}}, b_meas};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (b_write) begin
      running_sum <= sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      m_tdata <= {b_level[0], b_level[1], b_level, b_drop ? running_sum : sum_next};
      m_tuser <= b_drop;
    end
  end

`ifndef NO_ASSERTIONS
  // a range change arms the drop of the next sample
  a_drop_armed: assert property (@(posedge clk) disable iff (rst)
    (accept && !drop_pending && level_next != level) |=> drop_pending)
    else $error("range change did not arm a drop");

  // a dropped sample leaves level and ring position alone and clears the drop
  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && drop_pending) |=>
      (level == $past(level) && ring_position == $past(ring_position) && !drop_pending))
    else $error("dropped sample changed state");

  // the ring position stays inside the window
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ring_position <= PTR_LAST)
    else $error("ring position out of range");

  // the running sum only moves when a measurement is written back
  a_sum_quiet: assert property (@(posedge clk) disable iff (rst)
    !b_write |=> $stable(running_sum))
    else $error("running sum changed without a write-back");
`endif

endmodule
`default_nettype wire
